>>> rtl/redf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redf_pkg: shared definitions for the red-eye disk pixel filter
// Constants, the queue item type and the channel arithmetic helpers.
// ----------------------------------------------------------------------------
package redf_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int RADIUS_BITS     = 6;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [7:0]             CHAN_MAX     = 8'hFF;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 6'd15;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS   = 2'd2;

    // One classified pixel as it waits between the front and the back.
    typedef struct packed {
        logic [31:0] pixel;
        logic        in_disk;
        logic        scale_en;
        logic [7:0]  quot;
    } redf_item_t;

    // Truncated 255/a for a in 1..254. Other codes return 1.
    function automatic logic [7:0] recip255(input logic [7:0] a);
        logic [7:0] q;
        priority if (a == 8'd0)  q = 8'd1;
        else if (a >= 8'd128)    q = 8'd1;
        else if (a >= 8'd86)     q = 8'd2;
        else if (a >= 8'd64)     q = 8'd3;
        else if (a >= 8'd52)     q = 8'd4;
        else if (a >= 8'd43)     q = 8'd5;
        else if (a >= 8'd37)     q = 8'd6;
        else if (a >= 8'd32)     q = 8'd7;
        else if (a >= 8'd29)     q = 8'd8;
        else if (a >= 8'd26)     q = 8'd9;
        else if (a >= 8'd24)     q = 8'd10;
        else if (a >= 8'd22)     q = 8'd11;
        else if (a >= 8'd20)     q = 8'd12;
        else if (a == 8'd19)     q = 8'd13;
        else if (a == 8'd18)     q = 8'd14;
        else if (a >= 8'd16)     q = 8'd15;
        else if (a == 8'd15)     q = 8'd17;
        else if (a == 8'd14)     q = 8'd18;
        else if (a == 8'd13)     q = 8'd19;
        else if (a == 8'd12)     q = 8'd21;
        else if (a == 8'd11)     q = 8'd23;
        else if (a == 8'd10)     q = 8'd25;
        else if (a == 8'd9)      q = 8'd28;
        else if (a == 8'd8)      q = 8'd31;
        else if (a == 8'd7)      q = 8'd36;
        else if (a == 8'd6)      q = 8'd42;
        else if (a == 8'd5)      q = 8'd51;
        else if (a == 8'd4)      q = 8'd63;
        else if (a == 8'd3)      q = 8'd85;
        else if (a == 8'd2)      q = 8'd127;
        else                     q = 8'd255;
        return q;
    endfunction

    // Truncated p/255, exact for every p up to 255*255.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'(p >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

>>> rtl/red_eye_disk_pixel_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// red_eye_disk_pixel_filter_top: red-eye disk pixel filter
// Recolors pixels that fall inside a configurable disk.
// ----------------------------------------------------------------------------
// The filter takes one pixel request per clock while it has queue credit
// and returns one result per clock while m_tready is high, in the same
// order. With an empty queue a request passes seven register stages, the
// first loaded at the accepting edge: two classification stages, the queue
// write, and four recoloring stages ending in the output register. The
// input side holds a credit count against the eight-entry queue, so it
// keeps taking pixels while results wait on the output until eight requests
// sit in the classification stages and the queue; up to four more are held
// in the recoloring stages. Inside the disk, red is replaced by the mean of
// the alpha-corrected green and blue; outside it the pixel passes unchanged.
// m_tuser flags recolored pixels. Configuration writes are taken in any cycle
// on the cfg channel and should be made while no pixel is in flight.
module red_eye_disk_pixel_filter_top import redf_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int S_TDATA_BITS = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // cfg_data: register value, low bits used per register
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]     cfg_data,
    // s_tdata: pixel_x, pixel_y, pixel_in (from bit 0 up), zero padding on top
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [S_TDATA_BITS-1:0]   s_tdata,
    // m_tdata: pixel_out
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,
    // m_tuser: inside_disk
    output logic [0:0]                     m_tuser
);

    localparam int CREDIT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [CREDIT_BITS-1:0] credit_reg;
    logic [CREDIT_BITS-1:0] credit_next;
    logic                   in_accept;
    logic                   front_valid;
    redf_item_t             front_item;
    logic                   queue_empty;
    redf_item_t             queue_head;
    logic                   queue_pop;
    logic                   back_inside;

    assign cfg_ready = 1'b1;
    assign s_tready  = credit_reg < CREDIT_BITS'(QUEUE_DEPTH);
    assign in_accept = s_tvalid && s_tready;

    // Counts requests accepted but not yet taken out of the queue.
    always_comb begin
        credit_next = credit_reg;
        if (in_accept && !queue_pop) begin
            credit_next = credit_reg + 1'b1;
        end else if (queue_pop && !in_accept) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    redf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_accept),
        .pixel_x    (s_tdata[COORD_BITS-1:0]),
        .pixel_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .pixel_in   (s_tdata[2*COORD_BITS+31:2*COORD_BITS]),
        .item_valid (front_valid),
        .item       (front_item)
    );

    redf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_item (front_item),
        .pop       (queue_pop),
        .empty     (queue_empty),
        .head      (queue_head)
    );

    redf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (queue_head),
        .head_valid (!queue_empty),
        .pop        (queue_pop),
        .m_ready    (m_tready),
        .m_valid    (m_tvalid),
        .m_pixel    (m_tdata),
        .m_inside   (back_inside)
    );

    assign m_tuser = back_inside;

endmodule
`default_nettype wire

>>> rtl/redf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redf_front: disk classification
// Holds the configuration registers, measures the distance of each pixel
// from the disk center over two stages and looks up the alpha reciprocal.
// ----------------------------------------------------------------------------
module redf_front import redf_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]     cfg_data,
    input  wire logic                      in_valid,
    input  wire logic [COORD_BITS-1:0]     pixel_x,
    input  wire logic [COORD_BITS-1:0]     pixel_y,
    input  wire logic [31:0]               pixel_in,
    output logic                           item_valid,
    output redf_item_t                     item
);

    localparam int SQ_BITS = 2 * COORD_BITS;

    logic [COORD_BITS-1:0]  center_x_reg;
    logic [COORD_BITS-1:0]  center_y_reg;
    logic [RADIUS_BITS-1:0] radius_reg;

    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [31:0]           pix1_reg;
    logic [7:0]            quot1_reg;
    logic                  en1_reg;

    logic                     s2_valid_reg;
    logic [SQ_BITS-1:0]       dx2_reg;
    logic [SQ_BITS-1:0]       dy2_reg;
    logic [2*RADIUS_BITS-1:0] rr_reg;
    logic [31:0]              pix2_reg;
    logic [7:0]               quot2_reg;
    logic                     en2_reg;

    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_next;
    logic [7:0]            alpha;
    logic                  en_next;
    logic [SQ_BITS:0]      dist_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign dx_next = (pixel_x >= center_x_reg) ? pixel_x - center_x_reg
                                               : center_x_reg - pixel_x;
    assign dy_next = (pixel_y >= center_y_reg) ? pixel_y - center_y_reg
                                               : center_y_reg - pixel_y;
    assign alpha   = pixel_in[31:24];
    assign en_next = (alpha != 8'd0) && (alpha != CHAN_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        pix1_reg  <= pixel_in;
        quot1_reg <= en_next ? recip255(alpha) : 8'd1;
        en1_reg   <= en_next;

        dx2_reg   <= dx_reg * dx_reg;
        dy2_reg   <= dy_reg * dy_reg;
        rr_reg    <= radius_reg * radius_reg;
        pix2_reg  <= pix1_reg;
        quot2_reg <= quot1_reg;
        en2_reg   <= en1_reg;
    end

    assign dist_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    assign item_valid    = s2_valid_reg;
    assign item.pixel    = pix2_reg;
    assign item.in_disk  = dist_sum <= (SQ_BITS+1)'(rr_reg);
    assign item.scale_en = en2_reg;
    assign item.quot     = quot2_reg;

endmodule
`default_nettype wire

>>> rtl/redf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redf_queue: item queue between front and back
// A small register FIFO. The top level's credit count keeps it from
// overflowing, so a push is always taken.
// ----------------------------------------------------------------------------
module redf_queue import redf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  redf_item_t      push_item,
    input  wire logic       pop,
    output logic            empty,
    output redf_item_t      head
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    redf_item_t            mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

>>> rtl/redf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redf_back: recoloring pipeline
// Scales green and blue up by the alpha reciprocal, forms red, clamps,
// scales back down by alpha/255 and holds the result in the output register.
// ----------------------------------------------------------------------------
module redf_back import redf_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  redf_item_t head,
    input  wire logic  head_valid,
    output logic       pop,
    input  wire logic  m_ready,
    output logic       m_valid,
    output logic [31:0] m_pixel,
    output logic       m_inside
);

    function automatic logic [7:0] clamp8(input logic [15:0] c);
        return (c > 16'(CHAN_MAX)) ? CHAN_MAX : c[7:0];
    endfunction

    logic        v1_reg;
    logic [15:0] gu1_reg;
    logic [15:0] bu1_reg;
    logic [31:0] orig1_reg;
    logic        ins1_reg;
    logic        en1_reg;

    logic        v2_reg;
    logic [7:0]  rc2_reg;
    logic [7:0]  gc2_reg;
    logic [7:0]  bc2_reg;
    logic [31:0] orig2_reg;
    logic        ins2_reg;
    logic        en2_reg;

    logic        v3_reg;
    logic [15:0] pr3_reg;
    logic [15:0] pg3_reg;
    logic [15:0] pb3_reg;
    logic [31:0] orig3_reg;
    logic        ins3_reg;
    logic        en3_reg;

    logic        out_valid_reg;
    logic [31:0] out_pixel_reg;
    logic        out_inside_reg;

    logic        adv;
    logic [16:0] gb_sum;
    logic [7:0]  alpha2;
    logic [7:0]  r_next;
    logic [7:0]  g_next;
    logic [7:0]  b_next;
    logic [31:0] pixel_next;

    // The whole back pipeline moves together whenever the output can advance.
    assign adv = !out_valid_reg || m_ready;
    assign pop = adv && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= head_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign gb_sum = {1'b0, gu1_reg} + {1'b0, bu1_reg};
    assign alpha2 = orig2_reg[31:24];

    // Unscaled channels already sit below 256, so the divide by 255 is
    // bypassed for them at the last stage.
    assign r_next = en3_reg ? div255(pr3_reg) : pr3_reg[7:0];
    assign g_next = en3_reg ? div255(pg3_reg) : pg3_reg[7:0];
    assign b_next = en3_reg ? div255(pb3_reg) : pb3_reg[7:0];
    assign pixel_next = ins3_reg ? {orig3_reg[31:24], r_next, g_next, b_next} : orig3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            gu1_reg   <= head.pixel[15:8] * head.quot;
            bu1_reg   <= head.pixel[7:0] * head.quot;
            orig1_reg <= head.pixel;
            ins1_reg  <= head.in_disk;
            en1_reg   <= head.scale_en;

            rc2_reg   <= clamp8(gb_sum[16:1]);
            gc2_reg   <= clamp8(gu1_reg);
            bc2_reg   <= clamp8(bu1_reg);
            orig2_reg <= orig1_reg;
            ins2_reg  <= ins1_reg;
            en2_reg   <= en1_reg;

            pr3_reg   <= en2_reg ? rc2_reg * alpha2 : {8'd0, rc2_reg};
            pg3_reg   <= en2_reg ? gc2_reg * alpha2 : {8'd0, gc2_reg};
            pb3_reg   <= en2_reg ? bc2_reg * alpha2 : {8'd0, bc2_reg};
            orig3_reg <= orig2_reg;
            ins3_reg  <= ins2_reg;
            en3_reg   <= en2_reg;

            out_pixel_reg  <= pixel_next;
            out_inside_reg <= ins3_reg;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_pixel  = out_pixel_reg;
    assign m_inside = out_inside_reg;

endmodule
`default_nettype wire

>>> rtl/redf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redf_checker: port-level checks for the red-eye disk pixel filter
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module redf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    logic [7:0] a_out;
    logic [7:0] r_out;
    logic [7:0] g_out;
    logic [7:0] b_out;
    logic [8:0] gb_out;

    assign a_out  = m_tdata[31:24];
    assign r_out  = m_tdata[23:16];
    assign g_out  = m_tdata[15:8];
    assign b_out  = m_tdata[7:0];
    assign gb_out = {1'b0, g_out} + {1'b0, b_out};

    // After reset nothing is in flight: no result and room for requests.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("redf: result or stall right after reset");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("redf: stalled result changed");

    // Without alpha scaling, red is the plain mean of green and blue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && (a_out == 8'd0 || a_out == 8'hFF)
        |-> r_out == gb_out[8:1])
        else $error("redf: unscaled red is not the green-blue mean");

    // Scaling back down by alpha/255 never yields a channel above alpha.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && a_out != 8'd0 && a_out != 8'hFF
        |-> r_out <= a_out && g_out <= a_out && b_out <= a_out)
        else $error("redf: scaled channel exceeds alpha");

endmodule

bind red_eye_disk_pixel_filter_top redf_checker u_redf_checker (.*);
`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the red-eye disk pixel filter
// Streams pixel requests through the filter under random sender bursts and
// receiver stalls. Each accepted request is run through a local recoloring
// predictor, and each result is compared in order against its prediction.
// ----------------------------------------------------------------------------
module tb_top import redf_pkg::*; ();

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int S_BITS       = ((2 * COORD_W + 32 + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 8;

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] pixel;
        logic        in_disk;
    } filtered_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COORD_W-1:0]        cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_BITS-1:0]         s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [31:0]               m_tdata;
    logic [0:0]                m_tuser;

    // Local copy of the configuration registers.
    logic [COORD_W-1:0]     center_x = '0;
    logic [COORD_W-1:0]     center_y = '0;
    logic [RADIUS_BITS-1:0] radius   = RADIUS_RESET;

    filtered_t filtered_q[$];
    filtered_t expected;

    int errors      = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_inside    = 0;
    int n_cfg       = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int cycle_count = 0;

    red_eye_disk_pixel_filter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned scale_up(int unsigned c, int unsigned a);
        if (a > 0 && a < 255) return c * (255 / a);
        return c;
    endfunction

    function automatic int unsigned clamp_scale_down(int unsigned c, int unsigned a);
        int unsigned v;
        v = (c > 255) ? 255 : c;
        if (a > 0 && a < 255) v = (v * a) / 255;
        return v;
    endfunction

    // Recolors one pixel against the current disk settings.
    function automatic filtered_t filter_pixel(logic [COORD_W-1:0] px,
                                               logic [COORD_W-1:0] py,
                                               logic [31:0] pix);
        filtered_t   res;
        int unsigned dx, dy, rr, a, r, g, b;
        dx = (px >= center_x) ? int'(px) - int'(center_x) : int'(center_x) - int'(px);
        dy = (py >= center_y) ? int'(py) - int'(center_y) : int'(center_y) - int'(py);
        rr = int'(radius) * int'(radius);
        res.in_disk = (dx * dx + dy * dy) <= rr;
        res.pixel   = pix;
        if (res.in_disk) begin
            a = 32'(pix[31:24]);
            g = scale_up(32'(pix[15:8]), a);
            b = scale_up(32'(pix[7:0]), a);
            r = (g + b) / 2;
            r = clamp_scale_down(r, a);
            g = clamp_scale_down(g, a);
            b = clamp_scale_down(b, a);
            res.pixel = {pix[31:24], r[7:0], g[7:0], b[7:0]};
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, n_checked);
        errors++;
    endtask

    // Result side: check with the values seen before the edge, then pick the
    // next ready value from the current stall pattern.
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("result with no request waiting", m_tdata, '0);
            end else begin
                expected = filtered_q.pop_front();
                if (m_tdata !== expected.pixel)
                    report_mismatch("pixel_out", m_tdata, expected.pixel);
                if (m_tuser[0] !== expected.in_disk)
                    report_mismatch("inside_disk", 32'(m_tuser), 32'(expected.in_disk));
                if (expected.in_disk) n_inside++;
            end
            n_checked++;
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end
        stall_left--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle_count % 4) == 0;
            default: m_tready <= $urandom_range(0, 7) != 0;
        endcase
    end

    // Sends one pixel request; gaps fall between bursts of random length.
    task automatic send_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [31:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pix, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filtered_q.push_back(filter_pixel(px, py, pix));
        n_sent++;
        burst_left--;
    endtask

    // Stops sending and waits until every outstanding request has returned.
    task automatic wait_idle();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COORD_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_CENTER_X: center_x = val;
            CFG_CENTER_Y: center_y = val;
            CFG_RADIUS:   radius   = val[RADIUS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_disk(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [COORD_W-1:0] rad);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, rad);
    endtask

    // Disk at the origin with the reset radius; probes the boundary.
    task automatic test_reset_values();
        send_pixel(12'd0, 12'd0, 32'hFF_FF_00_FF);
        send_pixel(12'd15, 12'd0, 32'h80_10_20_30);
        send_pixel(12'd16, 12'd0, 32'h80_10_20_30);
        send_pixel(12'd0, 12'd15, 32'h01_FF_FF_FF);
        send_pixel(12'd11, 12'd11, 32'hFE_AA_55_AA);
        send_pixel(12'd10, 12'd11, 32'hFE_AA_55_AA);
    endtask

    // Alpha codes at and around the unscaled values, channel extremes.
    task automatic test_alpha_codes();
        set_disk(12'd100, 12'd200, 12'd50);
        send_pixel(12'd100, 12'd200, 32'h00_12_FF_FF);
        send_pixel(12'd101, 12'd200, 32'h01_00_FF_FF);
        send_pixel(12'd102, 12'd200, 32'h02_00_FF_01);
        send_pixel(12'd103, 12'd200, 32'h7F_FF_80_7F);
        send_pixel(12'd104, 12'd200, 32'h80_FF_FF_00);
        send_pixel(12'd105, 12'd200, 32'hFE_00_FE_FE);
        send_pixel(12'd150, 12'd200, 32'hFF_FF_FF_FF);
        send_pixel(12'd150, 12'd201, 32'h00_00_00_00);
    endtask

    // A zero radius recolors only the center pixel.
    task automatic test_radius_zero();
        set_disk(12'd2047, 12'd1024, 12'd0);
        send_pixel(12'd2047, 12'd1024, 32'h40_FF_20_60);
        send_pixel(12'd2048, 12'd1024, 32'h40_FF_20_60);
        send_pixel(12'd2047, 12'd1023, 32'h40_FF_20_60);
    endtask

    // Extreme centers and the widest radius; distances must not wrap.
    task automatic test_coordinate_limits();
        set_disk(12'hFFF, 12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 12'hFFF, 32'h30_01_02_03);
        send_pixel(12'd4032, 12'hFFF, 32'hC0_FF_FF_FF);
        send_pixel(12'd4031, 12'hFFF, 32'hC0_FF_FF_FF);
        send_pixel(12'd0, 12'd0, 32'h30_01_02_03);
        set_disk(12'd0, 12'd0, 12'd5);
        send_pixel(12'hFFF, 12'd0, 32'h30_01_02_03);
    endtask

    // A write to the spare index must leave the disk unchanged.
    task automatic test_unused_register();
        write_reg(CFG_UNUSED, 12'hA5A);
        send_pixel(12'd3, 12'd4, 32'h55_66_77_88);
        send_pixel(12'd4, 12'd4, 32'h55_66_77_88);
    endtask

    // Random pixels over several disk settings, most of them near the disk.
    task automatic test_random_stream();
        int                 span, off_x, off_y;
        logic [COORD_W-1:0] px, py, cx, cy, rad;
        logic [7:0]         alpha;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cx  = COORD_W'($urandom_range(0, 4095));
            cy  = COORD_W'($urandom_range(0, 4095));
            rad = COORD_W'($urandom_range(0, 4095));
            case (ph)
                0: begin cx = COORD_W'($urandom_range(0, 20));
                       cy = COORD_W'($urandom_range(0, 20));
                       rad = 12'd5; end
                1: begin cx = 12'hFFF - COORD_W'($urandom_range(0, 20));
                       rad = 12'd50; end
                2: rad = 12'd0;
                3: rad = 12'd63;
                default: if ($urandom_range(0, 1) == 0) rad = COORD_W'($urandom_range(5, 50));
            endcase
            set_disk(cx, cy, rad);
            span = int'(radius) + 3;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 3 && i == PHASE_ITEMS / 2) wait_idle();
                if ($urandom_range(0, 9) < 7) begin
                    off_x = $urandom_range(0, 2 * span) - span;
                    off_y = $urandom_range(0, 2 * span) - span;
                    px = center_x + off_x[COORD_W-1:0];
                    py = center_y + off_y[COORD_W-1:0];
                end else begin
                    px = COORD_W'($urandom_range(0, 4095));
                    py = COORD_W'($urandom_range(0, 4095));
                end
                case ($urandom_range(0, 7))
                    0: alpha = 8'd0;
                    1: alpha = 8'd255;
                    2: alpha = 8'($urandom_range(1, 15));
                    default: alpha = 8'($urandom_range(0, 255));
                endcase
                send_pixel(px, py, {alpha, 24'($urandom())});
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_alpha_codes();
        test_radius_zero();
        test_coordinate_limits();
        test_unused_register();
        test_random_stream();
        wait_idle();
        $display("Covered %0d pixel requests (%0d inside the disk) over %0d register writes,",
                 n_sent, n_inside, n_cfg);
        $display("with alpha extremes, zero and full radius, and random stalls on both sides.");
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("Timeout with %0d results still outstanding.", filtered_q.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
